// ----- design/gsmt_pkg.sv -----
// global sweep mppt tracker: shared types, widths, phase codes and register indexes
// used by every module of the tracker; no dependencies
package gsmt_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int DUTY_BITS      = 16;
    localparam int DUTY_REG_BITS  = DUTY_BITS + 1;
    localparam int POWER_BITS     = 2 * SAMPLE_BITS;
    localparam int RATIO_BITS     = 8;
    localparam int ESTIMATE_BITS  = POWER_BITS + RATIO_BITS;
    localparam int ENERGY_BITS    = 48;
    localparam int STEP_BITS      = 16;
    localparam int PHASE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int IN_TDATA_BITS  = 2 * SAMPLE_BITS;
    localparam int OUT_FIELD_BITS = DUTY_BITS + PHASE_BITS + 2 * POWER_BITS
                                    + ESTIMATE_BITS + ENERGY_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam logic [PHASE_BITS-1:0] PH_INIT   = 2'd0;
    localparam logic [PHASE_BITS-1:0] PH_SEARCH = 2'd1;
    localparam logic [PHASE_BITS-1:0] PH_DONE   = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_SIZE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWEEP_STEPS     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_LOW_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_HIGH_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACKING_ENABLE = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIXED_DUTY      = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PERIOD_RATIO    = 3'd6;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  step_size;
        logic [STEP_BITS-1:0]  sweep_steps;
        logic [DUTY_BITS-1:0]  duty_low_limit;
        logic [DUTY_BITS-1:0]  duty_high_limit;
        logic                  tracking_enable;
        logic [DUTY_BITS-1:0]  fixed_duty;
        logic [RATIO_BITS-1:0] period_ratio;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        step_size:       16'd3277,
        sweep_steps:     16'd20,
        duty_low_limit:  16'd3277,
        duty_high_limit: 16'd62258,
        tracking_enable: 1'b1,
        fixed_duty:      16'd32768,
        period_ratio:    8'd10
    };

    typedef struct packed {
        logic                   restart;
        logic [SAMPLE_BITS-1:0] voltage_sample;
        logic [SAMPLE_BITS-1:0] current_sample;
    } req_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]     duty_out;
        logic [PHASE_BITS-1:0]    phase;
        logic [POWER_BITS-1:0]    power_now;
        logic [POWER_BITS-1:0]    best_power;
        logic [ESTIMATE_BITS-1:0] power_estimate;
        logic [ENERGY_BITS-1:0]   energy_total;
    } res_t;

endpackage

// ----- design/gsmt_input_stage.sv -----
// input register of the tracker: takes a request from the slave stream
// and holds it until the sweep unit consumes it; depends on gsmt_pkg
module gsmt_input_stage (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gsmt_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    input  logic                                 s_tuser,
    output logic                                 req_valid,
    output gsmt_pkg::req_t                       req,
    input  logic                                 req_take
);
    import gsmt_pkg::*;

    logic valid_reg;
    logic valid_next;
    req_t req_reg;
    logic load;

    assign s_tready = !valid_reg || req_take;
    assign load     = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (req_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            req_reg.restart        <= s_tuser;
            req_reg.voltage_sample <= s_tdata[SAMPLE_BITS-1:0];
            req_reg.current_sample <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

// ----- design/gsmt_sweep_unit.sv -----
// sweep state and per-request arithmetic: power, energy total, sweep phases,
// best power and duty, estimate and duty clamp; depends on gsmt_pkg
module gsmt_sweep_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  gsmt_pkg::cfg_t  cfg,
    input  logic            req_valid,
    input  gsmt_pkg::req_t  req,
    output logic            req_take,
    input  logic            res_ready,
    output logic            res_valid,
    output gsmt_pkg::res_t  res
);
    import gsmt_pkg::*;

    logic [PHASE_BITS-1:0]    phase_reg, phase_next;
    logic [STEP_BITS-1:0]     step_counter_reg, step_counter_next;
    logic [DUTY_REG_BITS-1:0] duty_reg, duty_next;
    logic [POWER_BITS-1:0]    best_power_reg, best_power_next;
    logic [DUTY_BITS-1:0]     best_duty_reg, best_duty_next;
    logic [ESTIMATE_BITS-1:0] estimate_reg, estimate_next;
    logic [ENERGY_BITS-1:0]   energy_reg, energy_next;

    logic [POWER_BITS-1:0]    power;
    logic [ENERGY_BITS:0]     energy_sum;
    logic [ENERGY_BITS-1:0]   energy_sat;
    logic [DUTY_REG_BITS:0]   duty_sum;
    logic [DUTY_REG_BITS-1:0] duty_inc;
    logic [DUTY_BITS-1:0]     duty_cap;
    logic [ESTIMATE_BITS-1:0] estimate_prod;
    logic [DUTY_BITS-1:0]     duty_clamped;

    always_comb begin
        req_take = req_valid && res_ready;

        power      = POWER_BITS'(req.voltage_sample) * POWER_BITS'(req.current_sample);
        energy_sum = {1'b0, energy_reg} + (ENERGY_BITS+1)'(power);
        energy_sat = energy_sum[ENERGY_BITS] ? {ENERGY_BITS{1'b1}}
                                             : energy_sum[ENERGY_BITS-1:0];
        duty_sum   = {1'b0, duty_reg} + (DUTY_REG_BITS+1)'(cfg.step_size);
        duty_inc   = duty_sum[DUTY_REG_BITS] ? {DUTY_REG_BITS{1'b1}}
                                             : duty_sum[DUTY_REG_BITS-1:0];
        duty_cap   = duty_reg[DUTY_BITS] ? {DUTY_BITS{1'b1}} : duty_reg[DUTY_BITS-1:0];
        estimate_prod = ESTIMATE_BITS'(best_power_reg) * ESTIMATE_BITS'(cfg.period_ratio);

        phase_next        = phase_reg;
        step_counter_next = step_counter_reg;
        duty_next         = duty_reg;
        best_power_next   = best_power_reg;
        best_duty_next    = best_duty_reg;
        estimate_next     = estimate_reg;
        energy_next       = energy_reg;

        if (req_take) begin
            if (req.restart) begin
                phase_next = PH_INIT;
            end else begin
                energy_next = energy_sat;
                case (phase_reg)
                    PH_INIT: begin
                        step_counter_next = '0;
                        duty_next         = DUTY_REG_BITS'(cfg.step_size);
                        best_power_next   = '0;
                        best_duty_next    = '0;
                        phase_next        = PH_SEARCH;
                        energy_next       = '0;
                        estimate_next     = '0;
                    end
                    PH_SEARCH: begin
                        if (step_counter_reg < cfg.sweep_steps) begin
                            if (power > best_power_reg) begin
                                best_power_next = power;
                                best_duty_next  = duty_cap;
                            end
                            duty_next = duty_inc;
                        end else begin
                            phase_next    = PH_DONE;
                            duty_next     = DUTY_REG_BITS'(best_duty_reg);
                            estimate_next = estimate_prod;
                        end
                    end
                    PH_DONE: begin
                        phase_next = PH_DONE;
                    end
                    default: begin
                        phase_next = PH_INIT;
                    end
                endcase
                if (!cfg.tracking_enable) begin
                    duty_next = DUTY_REG_BITS'(cfg.fixed_duty);
                end
                step_counter_next = step_counter_next + 1'b1;
            end
        end

        // high limit is checked first and wins for any duty at or above it
        if (duty_next >= DUTY_REG_BITS'(cfg.duty_high_limit)) begin
            duty_clamped = cfg.duty_high_limit;
        end else if (duty_next <= DUTY_REG_BITS'(cfg.duty_low_limit)) begin
            duty_clamped = cfg.duty_low_limit;
        end else begin
            duty_clamped = duty_next[DUTY_BITS-1:0];
        end

        res_valid          = req_take && !req.restart;
        res.duty_out       = duty_clamped;
        res.phase          = phase_next;
        res.power_now      = power;
        res.best_power     = best_power_next;
        res.power_estimate = estimate_next;
        res.energy_total   = energy_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_INIT;
            step_counter_reg <= STEP_BITS'(1);
            duty_reg         <= '0;
            best_power_reg   <= '0;
            best_duty_reg    <= '0;
            estimate_reg     <= '0;
            energy_reg       <= '0;
        end else begin
            phase_reg        <= phase_next;
            step_counter_reg <= step_counter_next;
            duty_reg         <= duty_next;
            best_power_reg   <= best_power_next;
            best_duty_reg    <= best_duty_next;
            estimate_reg     <= estimate_next;
            energy_reg       <= energy_next;
        end
    end

    a_restart_to_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && req.restart) |=> (phase_reg == PH_INIT) && $stable(step_counter_reg))
        else $error("restart did not return the sweep to init");

    a_init_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && !req.restart && (phase_reg == PH_INIT))
        |=> (phase_reg == PH_SEARCH) && (energy_reg == '0) && (estimate_reg == '0)
            && (step_counter_reg == STEP_BITS'(1)))
        else $error("init tick did not restart the sweep");

    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_take && !req.restart && (phase_reg == PH_SEARCH)
            && (step_counter_reg >= cfg.sweep_steps))
        |=> (phase_reg == PH_DONE))
        else $error("sweep did not settle after its step count");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !req_take |=> $stable(phase_reg) && $stable(energy_reg) && $stable(best_power_reg))
        else $error("sweep state changed without a request");

endmodule

// ----- design/gsmt_output_stage.sv -----
// result register of the tracker: holds a finished result for the master
// stream and packs it into tdata; depends on gsmt_pkg
module gsmt_output_stage (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  res_valid,
    input  gsmt_pkg::res_t                        res,
    output logic                                  res_ready,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gsmt_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);
    import gsmt_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign res_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_BITS-OUT_FIELD_BITS){1'b0}},
                       res_reg.energy_total, res_reg.power_estimate, res_reg.best_power,
                       res_reg.power_now, res_reg.phase, res_reg.duty_out};

endmodule

// ----- design/global_sweep_mppt_tracker_core.sv -----
// global sweep mppt tracker top level: configuration registers and the
// input register, sweep unit and result register; depends on gsmt_pkg
//
// Takes one request per clock cycle while the master side takes results: a
// request is held in the input register, the sweep unit then forms the
// 16x16 power product, the energy sum, the sweep step and the duty clamp
// combinationally and loads the result register, so a result shows on the
// master side once it has passed the input register and the result register.
// A measurement tick gives exactly one result; a restart request gives none
// and only returns the sweep to init. The input register can hold the next
// request while a finished result still waits. Configuration writes take
// effect at once and are meant for times when no request is in flight.
module global_sweep_mppt_tracker_core (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // voltage_sample [15:0], current_sample [31:16]
    input  logic [gsmt_pkg::IN_TDATA_BITS-1:0]    s_tdata,
    // req_type (1 restarts the sweep)
    input  logic                                  s_tuser,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // duty_out [15:0], phase [17:16], power_now [49:18], best_power [81:50],
    // power_estimate [121:82], energy_total [169:122], zero fill [175:170]
    output logic [gsmt_pkg::OUT_TDATA_BITS-1:0]   m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic                                  cfg_wr_en,
    input  logic [gsmt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [gsmt_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import gsmt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic req_valid;
    req_t req;
    logic req_take;
    logic res_ready;
    logic res_valid;
    res_t res;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_STEP_SIZE:       cfg_next.step_size       = cfg_wdata[DUTY_BITS-1:0];
                REG_SWEEP_STEPS:     cfg_next.sweep_steps     = cfg_wdata[STEP_BITS-1:0];
                REG_DUTY_LOW_LIMIT:  cfg_next.duty_low_limit  = cfg_wdata[DUTY_BITS-1:0];
                REG_DUTY_HIGH_LIMIT: cfg_next.duty_high_limit = cfg_wdata[DUTY_BITS-1:0];
                REG_TRACKING_ENABLE: cfg_next.tracking_enable = cfg_wdata[0];
                REG_FIXED_DUTY:      cfg_next.fixed_duty      = cfg_wdata[DUTY_BITS-1:0];
                REG_PERIOD_RATIO:    cfg_next.period_ratio    = cfg_wdata[RATIO_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    gsmt_input_stage u_input_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    gsmt_sweep_unit u_sweep_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    gsmt_output_stage u_output_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- bench/gsmt_tb_pkg.sv -----
// scoreboard for the global sweep mppt tracker bench: predicts each tick
// result from its own copy of the settings and sweep state; depends on gsmt_pkg
package gsmt_tb_pkg;

    import gsmt_pkg::*;

    class tracker_scoreboard;

        cfg_t                       settings;
        logic [PHASE_BITS-1:0]      sweep_phase;
        logic [STEP_BITS-1:0]       tick_count;
        logic [DUTY_REG_BITS-1:0]   duty_acc;
        logic [POWER_BITS-1:0]      peak_power;
        logic [DUTY_BITS-1:0]       peak_duty;
        logic [ESTIMATE_BITS-1:0]   estimate;
        logic [ENERGY_BITS-1:0]     energy;
        res_t                       expected_results[$];
        int                         error_count;

        function new();
            settings    = CFG_RESET;
            sweep_phase = PH_INIT;
            tick_count  = STEP_BITS'(1);
            duty_acc    = '0;
            peak_power  = '0;
            peak_duty   = '0;
            estimate    = '0;
            energy      = '0;
            error_count = 0;
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction

        function void note_request(req_t r);
            logic [POWER_BITS-1:0]    power;
            logic [ENERGY_BITS:0]     energy_sum;
            logic [DUTY_REG_BITS:0]   duty_sum;
            logic [DUTY_REG_BITS-1:0] d;
            res_t                     res;
            if (r.restart) begin
                sweep_phase = PH_INIT;
                return;
            end
            power      = r.voltage_sample * r.current_sample;
            energy_sum = {1'b0, energy} + power;
            energy     = energy_sum[ENERGY_BITS] ? '1 : energy_sum[ENERGY_BITS-1:0];
            case (sweep_phase)
                PH_INIT: begin
                    tick_count  = '0;
                    duty_acc    = {1'b0, settings.step_size};
                    peak_power  = '0;
                    peak_duty   = '0;
                    sweep_phase = PH_SEARCH;
                    energy      = '0;
                    estimate    = '0;
                end
                PH_SEARCH: begin
                    if (tick_count < settings.sweep_steps) begin
                        if (power > peak_power) begin
                            peak_power = power;
                            peak_duty  = duty_acc[DUTY_BITS] ? '1 : duty_acc[DUTY_BITS-1:0];
                        end
                        duty_sum = {1'b0, duty_acc} + settings.step_size;
                        duty_acc = duty_sum[DUTY_REG_BITS] ? '1 : duty_sum[DUTY_REG_BITS-1:0];
                    end else begin
                        sweep_phase = PH_DONE;
                        duty_acc    = {1'b0, peak_duty};
                        estimate    = peak_power * settings.period_ratio;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    sweep_phase = PH_INIT;
                end
            endcase
            if (!settings.tracking_enable)
                duty_acc = {1'b0, settings.fixed_duty};
            tick_count = tick_count + 1'b1;

            d = duty_acc;
            if (d >= settings.duty_high_limit)
                res.duty_out = settings.duty_high_limit;
            else if (d <= settings.duty_low_limit)
                res.duty_out = settings.duty_low_limit;
            else
                res.duty_out = d[DUTY_BITS-1:0];
            res.phase          = sweep_phase;
            res.power_now      = power;
            res.best_power     = peak_power;
            res.power_estimate = estimate;
            res.energy_total   = energy;
            expected_results.push_back(res);
        endfunction

        function void report(string field, logic [ENERGY_BITS-1:0] want,
                             logic [ENERGY_BITS-1:0] got);
            error_count++;
            if (error_count <= 10)
                $display("mismatch %s: expected %0h, got %0h", field, want, got);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.duty_out !== want.duty_out)
                report("duty_out", want.duty_out, got.duty_out);
            if (got.phase !== want.phase)
                report("phase", want.phase, got.phase);
            if (got.power_now !== want.power_now)
                report("power_now", want.power_now, got.power_now);
            if (got.best_power !== want.best_power)
                report("best_power", want.best_power, got.best_power);
            if (got.power_estimate !== want.power_estimate)
                report("power_estimate", want.power_estimate, got.power_estimate);
            if (got.energy_total !== want.energy_total)
                report("energy_total", want.energy_total, got.energy_total);
        endfunction

    endclass

endpackage

// ----- bench/tb_global_sweep_mppt_tracker_core.sv -----
// testbench top for global_sweep_mppt_tracker_core: directed and random
// sweeps under several register settings, with sender gaps and receiver
// stalls; depends on gsmt_pkg and gsmt_tb_pkg
module tb_global_sweep_mppt_tracker_core;

    timeunit 1ns;
    timeprecision 1ps;

    import gsmt_pkg::*;
    import gsmt_tb_pkg::*;

    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 150;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic [IN_TDATA_BITS-1:0]   s_tdata   = '0;
    logic                       s_tuser   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [OUT_TDATA_BITS-1:0]  m_tdata;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;

    logic [15:0]                ready_bits = 16'hFFFF;
    logic [3:0]                 ready_pos  = '0;
    int                         burst_left = 0;
    bit                         steady     = 1'b1;

    tracker_scoreboard sb = new();

    always #5 aclk = ~aclk;

    global_sweep_mppt_tracker_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(req_t'({s_tuser, s_tdata[15:0], s_tdata[31:16]}));
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(res_t'({m_tdata[15:0], m_tdata[17:16], m_tdata[49:18],
                                    m_tdata[81:50], m_tdata[121:82], m_tdata[169:122]}));
    end

    // receiver stall pattern, renewed whenever ready_pos wraps around the 16-bit pattern
    always @(posedge aclk) begin
        if (ready_pos == 4'd15) begin
            case ($urandom_range(0, 3))
                0: ready_bits <= 16'hFFFF;
                1: ready_bits <= 16'h0F0F;
                2: ready_bits <= 16'h0001;
                default: ready_bits <= 16'($urandom);
            endcase
        end
        m_tready  <= ready_bits[ready_pos];
        ready_pos <= ready_pos + 1'b1;
    end

    function automatic req_t make_req(bit restart, logic [15:0] v, logic [15:0] c);
        req_t r;
        r.restart        = restart;
        r.voltage_sample = v;
        r.current_sample = c;
        return r;
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick16(int lo);
        case ($urandom_range(0, 5))
            0: return 16'(lo);
            1: return 16'hFFFF;
            default: return 16'($urandom_range(lo, 65535));
        endcase
    endfunction

    function automatic cfg_t random_settings(int k);
        cfg_t c;
        logic [15:0] a;
        logic [15:0] b;
        if (k == 0) begin
            c = '{step_size: 16'd1, sweep_steps: 16'd1, duty_low_limit: 16'd0,
                  duty_high_limit: 16'd0, tracking_enable: 1'b0, fixed_duty: 16'd0,
                  period_ratio: 8'd1};
        end else if (k == 1) begin
            c = '{step_size: 16'hFFFF, sweep_steps: 16'd2, duty_low_limit: 16'hFFFF,
                  duty_high_limit: 16'hFFFF, tracking_enable: 1'b1,
                  fixed_duty: 16'hFFFF, period_ratio: 8'd255};
        end else begin
            c.step_size       = ($urandom_range(0, 2) == 0) ? pick16(1)
                                : 16'($urandom_range(1, 8000));
            c.sweep_steps     = (k == 2) ? 16'hFFFF : 16'($urandom_range(1, 30));
            a                 = pick16(0);
            b                 = pick16(0);
            // mostly ordered limits, sometimes crossed
            if ($urandom_range(0, 4) == 0) begin
                c.duty_low_limit  = a;
                c.duty_high_limit = b;
            end else begin
                c.duty_low_limit  = 16'($urandom_range(0, 20000));
                c.duty_high_limit = 16'($urandom_range(40000, 65535));
            end
            c.tracking_enable = ($urandom_range(0, 3) != 0);
            c.fixed_duty      = pick16(0);
            c.period_ratio    = 8'($urandom_range(1, 255));
        end
        return c;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] reg_value(cfg_t c,
                                                         logic [CFG_INDEX_BITS-1:0] idx);
        case (idx)
            REG_STEP_SIZE:       return c.step_size;
            REG_SWEEP_STEPS:     return c.sweep_steps;
            REG_DUTY_LOW_LIMIT:  return c.duty_low_limit;
            REG_DUTY_HIGH_LIMIT: return c.duty_high_limit;
            REG_TRACKING_ENABLE: return CFG_DATA_BITS'(c.tracking_enable);
            REG_FIXED_DUTY:      return c.fixed_duty;
            REG_PERIOD_RATIO:    return CFG_DATA_BITS'(c.period_ratio);
            default:             return CFG_DATA_BITS'($urandom);
        endcase
    endfunction

    // writes every register, then one write to an unused index
    task automatic apply_settings(cfg_t c);
        logic [CFG_INDEX_BITS-1:0] idx;
        idx = REG_STEP_SIZE;
        do begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= reg_value(c, idx);
            @(posedge aclk);
            idx = idx + 1'b1;
        end while (idx != REG_STEP_SIZE);
        cfg_wr_en   <= 1'b0;
        sb.settings = c;
    endtask

    task automatic send_request(req_t r);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r.restart;
        s_tdata  <= {r.current_sample, r.voltage_sample};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.outstanding() > 0);
    endtask

    // a restart leaves no result behind, so let the pipeline empty too
    task automatic quiesce();
        wait_for_results();
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    initial begin
        cfg_t c;
        int   items;
        int   n;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: init tick, extreme samples, restart
        send_request(make_req(1'b0, 16'h0000, 16'h0000));
        send_request(make_req(1'b0, 16'hFFFF, 16'hFFFF));
        send_request(make_req(1'b0, 16'h0001, 16'hFFFF));
        send_request(make_req(1'b0, 16'hFFFF, 16'h0001));
        send_request(make_req(1'b0, 16'h8000, 16'h8000));
        send_request(make_req(1'b0, 16'hAAAA, 16'h5555));
        send_request(make_req(1'b1, 16'h5555, 16'hAAAA));
        send_request(make_req(1'b0, 16'h1234, 16'h5678));
        send_request(make_req(1'b0, 16'h0000, 16'hFFFF));
        quiesce();

        // full-scale steps: duty and best duty saturate, sweep finishes
        c = '{step_size: 16'hFFFF, sweep_steps: 16'd3, duty_low_limit: 16'd0,
              duty_high_limit: 16'hFFFF, tracking_enable: 1'b1, fixed_duty: 16'h1234,
              period_ratio: 8'd255};
        apply_settings(c);
        send_request(make_req(1'b1, 16'h0000, 16'h0000));
        send_request(make_req(1'b0, 16'h0010, 16'h0010));
        send_request(make_req(1'b0, 16'h0100, 16'h0100));
        send_request(make_req(1'b0, 16'h1000, 16'h1000));
        send_request(make_req(1'b0, 16'hFFFF, 16'hFFFF));
        send_request(make_req(1'b0, 16'h7FFF, 16'h0003));
        send_request(make_req(1'b0, 16'h0002, 16'h0002));
        send_request(make_req(1'b1, 16'hFFFF, 16'hFFFF));
        send_request(make_req(1'b0, 16'hFFFF, 16'hFFFF));
        quiesce();

        for (int k = 0; k < NUM_PHASES; k++) begin
            c = random_settings(k);
            apply_settings(c);
            steady = (k % 3 == 2);
            items  = 0;
            while (items < ITEMS_PER_PHASE) begin
                send_request(make_req(1'b1, random_sample(), random_sample()));
                items++;
                n = (c.sweep_steps > 40) ? 40 : c.sweep_steps + $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 29) == 0) begin
                        send_request(make_req(1'b1, random_sample(), random_sample()));
                        items++;
                    end
                    send_request(make_req(1'b0, random_sample(), random_sample()));
                    items++;
                    if ($urandom_range(0, 79) == 0)
                        wait_for_results();
                end
            end
            quiesce();
        end

        repeat (8) @(posedge aclk);
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/gsmt_pkg.sv
design/gsmt_input_stage.sv
design/gsmt_sweep_unit.sv
design/gsmt_output_stage.sv
design/global_sweep_mppt_tracker_core.sv
bench/gsmt_tb_pkg.sv
bench/tb_global_sweep_mppt_tracker_core.sv
